// ----- rtl/linear_probe_hash_table_macros.svh -----
// Assertion helpers used by lpht_back.sv. Every check is clocked on clk and
// is held off while rst_n is low.
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH

// The property must hold at every clock edge out of reset.
`define LPHT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be true at a clock edge out of reset.
`define LPHT_ASSERT_NEVER(label, cond, msg) \
  `LPHT_ASSERT(label, !(cond), msg)

`endif

// ----- rtl/lpht_pkg.sv -----
`timescale 1ns / 1ps

package lpht_pkg;

  // Field widths of the channels.
  localparam int KEY_W      = 31;
  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 3;
  localparam int OUT_SLOT_W = 5;

  // Home slot as carried between the halves; wide enough for the largest table.
  localparam int HOME_W = 12;

  // Default table size.
  localparam int TABLE_SIZE_DEF = 32;

  // Home slot reduction: the key is padded and consumed a byte per cycle.
  localparam int STEP_BITS    = 8;
  localparam int KEY_PAD_W    = 32;
  localparam int REDUCE_STEPS = KEY_PAD_W / STEP_BITS;
  localparam int STEP_CNT_W   = $clog2(REDUCE_STEPS);

  // Queue between the halves; the depth is a power of two.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Operation codes.
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

  // Result codes.
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd5;

  // Slot marks.
  localparam int MARK_W = 2;
  localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
  localparam logic [MARK_W-1:0] MARK_USED  = 2'd1;
  localparam logic [MARK_W-1:0] MARK_GONE  = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [OUT_SLOT_W-1:0] slot;
  } out_item_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key;
    logic [HOME_W-1:0] home;
  } work_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_REDUCE,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_READ,
    B_EVAL
  } back_state_t;

endpackage

// ----- rtl/lpht_front.sv -----
`timescale 1ns / 1ps

module lpht_front #(
  parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  lpht_pkg::in_item_t item,
  output logic              ready,
  input  logic              q_full,
  output logic              q_push,
  output lpht_pkg::work_t   q_data
);
  import lpht_pkg::*;

  localparam int SLOT_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam logic [SLOT_W:0] MODULUS = (SLOT_W + 1)'(TABLE_SIZE);
  localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(REDUCE_STEPS - 1);

  front_state_t           state_r, state_nxt;
  logic [STEP_CNT_W-1:0]  step_r, step_nxt;
  logic [KEY_PAD_W-1:0]   key_sh_r, key_sh_nxt;
  logic [SLOT_W-1:0]      rem_r, rem_nxt;
  logic [MODE_W-1:0]      mode_r, mode_nxt;
  logic [KEY_W-1:0]       key_r, key_nxt;
  logic [SLOT_W-1:0]      rem;
  logic [SLOT_W:0]        trial;
  logic [SLOT_W-1:0]      rem_step;

  // Remainder update over one byte of the key, most significant bit first.
  always_comb begin
    rem   = rem_r;
    trial = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      trial = {rem, key_sh_r[KEY_PAD_W-1-i]};
      if (trial >= MODULUS) begin
        trial = trial - MODULUS;
      end
      rem = trial[SLOT_W-1:0];
    end
    rem_step = rem;
  end

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    key_sh_nxt = key_sh_r;
    rem_nxt    = rem_r;
    mode_nxt   = mode_r;
    key_nxt    = key_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          state_nxt  = F_REDUCE;
          step_nxt   = '0;
          key_sh_nxt = KEY_PAD_W'(item.key);
          rem_nxt    = '0;
          mode_nxt   = item.mode;
          key_nxt    = item.key;
        end
      end
      F_REDUCE: begin
        rem_nxt    = rem_step;
        key_sh_nxt = key_sh_r << STEP_BITS;
        step_nxt   = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    ready       = (state_r == F_IDLE);
    q_push      = (state_r == F_PUSH) && !q_full;
    q_data.mode = mode_r;
    q_data.key  = key_r;
    q_data.home = HOME_W'(rem_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
    key_sh_r <= key_sh_nxt;
    rem_r    <= rem_nxt;
    mode_r   <= mode_nxt;
    key_r    <= key_nxt;
  end

endmodule

// ----- rtl/lpht_queue.sv -----
`timescale 1ns / 1ps

module lpht_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  lpht_pkg::work_t wr_data,
  output logic            full,
  input  logic            rd_en,
  output lpht_pkg::work_t rd_data,
  output logic            empty
);
  import lpht_pkg::*;

  work_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              wr_ok;
  logic              rd_ok;

  assign full    = (count_r == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign wr_ok   = wr_en && !full;
  assign rd_ok   = rd_en && !empty;
  assign rd_data = entries[rd_ptr_r];

  // Pointers wrap on their own since the depth is a power of two.
  always_comb begin
    wr_ptr_nxt = wr_ok ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_ok ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (wr_ok && !rd_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_ok && !wr_ok) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (wr_ok) begin
      entries[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- rtl/lpht_back.sv -----
`timescale 1ns / 1ps
`include "linear_probe_hash_table_macros.svh"

module lpht_back #(
  parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  lpht_pkg::work_t     q_data,
  output logic                q_pop,
  input  logic                res_ready,
  output logic                res_valid,
  output lpht_pkg::out_item_t res_item,
  output logic                clearing
);
  import lpht_pkg::*;

  localparam int SLOT_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SIZE - 1);
  localparam int WORD_W = MARK_W + KEY_W;

  // Each word holds the slot mark above the stored key.
  logic [WORD_W-1:0] mem [TABLE_SIZE];
  logic [WORD_W-1:0] rd_q;

  back_state_t       state_r, state_nxt;
  logic [SLOT_W-1:0] clr_idx_r, clr_idx_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [SLOT_W-1:0] cnt_r, cnt_nxt;
  logic              have_free_r, have_free_nxt;
  logic [SLOT_W-1:0] free_idx_r, free_idx_nxt;
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;

  logic [MARK_W-1:0]     mark;
  logic [KEY_W-1:0]      stored_key;
  logic                  hit;
  logic                  free_here;
  logic                  is_last;
  logic                  ev_finish;
  logic                  ev_write;
  logic [STATUS_W-1:0]   ev_status;
  logic [OUT_SLOT_W-1:0] ev_slot;
  logic [SLOT_W-1:0]     ev_target;
  logic [WORD_W-1:0]     ev_wdata;

  logic              re;
  logic              we;
  logic [SLOT_W-1:0] waddr;
  logic [WORD_W-1:0] wdata;

  assign mark       = rd_q[KEY_W +: MARK_W];
  assign stored_key = rd_q[KEY_W-1:0];
  assign hit        = (mark == MARK_USED) && (stored_key == key_r);
  assign free_here  = (mark != MARK_USED);
  assign is_last    = (cnt_r == LAST_SLOT);

  // Decision for the slot just read.
  always_comb begin
    ev_finish = 1'b0;
    ev_write  = 1'b0;
    ev_status = ST_NOT_FOUND;
    ev_slot   = '0;
    ev_target = idx_r;
    ev_wdata  = rd_q;
    unique case (mode_r)
      MODE_INSERT: begin
        if (hit) begin
          ev_finish = 1'b1;
          ev_status = ST_DUPLICATE;
          ev_slot   = OUT_SLOT_W'(idx_r);
        end else if ((mark == MARK_EMPTY) || (is_last && (have_free_r || free_here))) begin
          ev_finish = 1'b1;
          ev_status = ST_INSERTED;
          ev_target = have_free_r ? free_idx_r : idx_r;
          ev_slot   = OUT_SLOT_W'(ev_target);
          ev_write  = 1'b1;
          ev_wdata  = {MARK_USED, key_r};
        end else if (is_last) begin
          ev_finish = 1'b1;
          ev_status = ST_FULL;
        end
      end
      MODE_SEARCH: begin
        if (hit) begin
          ev_finish = 1'b1;
          ev_status = ST_FOUND;
          ev_slot   = OUT_SLOT_W'(idx_r);
        end else if ((mark == MARK_EMPTY) || is_last) begin
          ev_finish = 1'b1;
        end
      end
      MODE_DELETE: begin
        if (hit) begin
          ev_finish = 1'b1;
          ev_status = ST_DELETED;
          ev_slot   = OUT_SLOT_W'(idx_r);
          ev_write  = 1'b1;
          ev_wdata  = {MARK_GONE, stored_key};
        end else if ((mark == MARK_EMPTY) || is_last) begin
          ev_finish = 1'b1;
        end
      end
      default: ev_finish = 1'b1;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    have_free_nxt = have_free_r;
    free_idx_nxt  = free_idx_r;
    mode_nxt      = mode_r;
    key_nxt       = key_r;
    unique case (state_r)
      B_CLEAR: begin
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == LAST_SLOT) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!q_empty) begin
          state_nxt     = B_READ;
          mode_nxt      = q_data.mode;
          key_nxt       = q_data.key;
          idx_nxt       = q_data.home[SLOT_W-1:0];
          cnt_nxt       = '0;
          have_free_nxt = 1'b0;
          free_idx_nxt  = '0;
        end
      end
      B_READ: begin
        state_nxt = B_EVAL;
      end
      B_EVAL: begin
        if (ev_finish) begin
          if (res_ready) begin
            state_nxt = B_IDLE;
          end
        end else begin
          state_nxt = B_READ;
          idx_nxt   = (idx_r == LAST_SLOT) ? '0 : idx_r + 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
          if (!have_free_r && (mode_r == MODE_INSERT) && free_here) begin
            have_free_nxt = 1'b1;
            free_idx_nxt  = idx_r;
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (state_r == B_IDLE) && !q_empty;
    clearing  = (state_r == B_CLEAR);
    re        = (state_r == B_READ);
    res_valid = (state_r == B_EVAL) && ev_finish && res_ready;
    res_item.status = ev_status;
    res_item.slot   = ev_slot;
    we    = 1'b0;
    waddr = ev_target;
    wdata = ev_wdata;
    if (state_r == B_CLEAR) begin
      we    = 1'b1;
      waddr = clr_idx_r;
      wdata = {MARK_EMPTY, {KEY_W{1'b0}}};
    end else if (res_valid && ev_write) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
    idx_r       <= idx_nxt;
    cnt_r       <= cnt_nxt;
    have_free_r <= have_free_nxt;
    free_idx_r  <= free_idx_nxt;
    mode_r      <= mode_nxt;
    key_r       <= key_nxt;
  end

  `LPHT_ASSERT(a_write_state, we |-> (state_r == B_EVAL || state_r == B_CLEAR), "table write outside clear or evaluate")
  `LPHT_ASSERT(a_result_room, res_valid |-> res_ready, "result issued with no room at the output")
  `LPHT_ASSERT_NEVER(a_pop_busy, q_pop && (state_r != B_IDLE), "queue popped while a probe is in flight")
  `LPHT_ASSERT(a_read_then_eval, (state_r == B_READ) |=> (state_r == B_EVAL), "read not followed by evaluate")

endmodule

// ----- rtl/linear_probe_hash_table.sv -----
`timescale 1ns / 1ps

// Open-addressing hash table of keys with linear probing. Each input beat
// carries an operation (insert, search or delete) and a 31-bit key, and
// produces exactly one result beat with a status code and the low five bits
// of the slot index involved. The home slot is the key modulo TABLE_SIZE,
// and probing steps to the next slot, wrapping at the end, until it meets the
// key or a never-used slot, or has visited every slot. Deleted slots become
// tombstones that searches probe past and inserts reuse. Both channels behave
// as queues: an input beat is taken when push is high and full is low, and a
// result beat leaves when pop is high and empty is low. After reset the table
// is swept to empty, one slot per cycle; full stays high during that sweep.
// The front half takes one beat and reduces the key to its home slot, a byte
// of the key per cycle, then hands it to a two-entry queue; it takes a new
// beat only once the last has been pushed into that queue. The back half pops
// an entry in its idle state, then passes a read state and an evaluate state
// for each slot probed, since every probe is a registered read of the slot
// memory followed by a compare; a finished result waits in the evaluate state
// until the output register has room. Probes per operation thus set the
// sustained rate under any real load; a table at light load gives a few
// probes per beat. Results wait in an output register, so the back half goes
// on with the next entry while a result is still waiting to be popped.
module linear_probe_hash_table #(
  parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  lpht_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output lpht_pkg::out_item_t out_item
);
  import lpht_pkg::*;

  logic      front_ready;
  logic      accept;
  logic      fq_push;
  logic      fq_full;
  work_t     fq_wdata;
  work_t     fq_rdata;
  logic      fq_empty;
  logic      fq_pop;
  logic      clearing;
  logic      res_ready;
  logic      res_valid;
  out_item_t res_item;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;

  // Nothing is taken while the sweep after reset is running.
  assign full   = !front_ready || clearing;
  assign accept = push && !full;

  lpht_front #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .accept(accept),
    .item  (in_item),
    .ready (front_ready),
    .q_full(fq_full),
    .q_push(fq_push),
    .q_data(fq_wdata)
  );

  lpht_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (fq_push),
    .wr_data(fq_wdata),
    .full   (fq_full),
    .rd_en  (fq_pop),
    .rd_data(fq_rdata),
    .empty  (fq_empty)
  );

  lpht_back #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (fq_empty),
    .q_data   (fq_rdata),
    .q_pop    (fq_pop),
    .res_ready(res_ready),
    .res_valid(res_valid),
    .res_item (res_item),
    .clearing (clearing)
  );

  // The output register takes a new result when it is empty or when its
  // current beat is being popped in the same cycle.
  assign res_ready = !out_valid_r || pop;
  assign empty     = !out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (res_valid) begin
      out_item_r <= res_item;
    end
  end

endmodule

// ----- tb/hash_table_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels of the hash table. It keeps its own copy of the slot
// store, works out the answer for every accepted operation beat, and checks
// each result beat against the oldest answer still waiting.
module hash_table_checker #(
  parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic                full,
  input  lpht_pkg::in_item_t  in_item,
  input  logic                empty,
  input  logic                pop,
  input  lpht_pkg::out_item_t out_item,
  output int                  fail_count,
  output int                  outstanding,
  output int                  beats_checked,
  output int                  full_seen,
  output int                  dup_seen,
  output int                  deleted_seen,
  output int                  longest_probe
);

  import lpht_pkg::*;

  logic [KEY_W-1:0]  shadow_key  [TABLE_SIZE];
  logic [MARK_W-1:0] shadow_mark [TABLE_SIZE];
  out_item_t         pending_answers [$];

  // One linear probe from the home slot serves all three operations: it stops
  // at a never-used slot or at the key, and remembers the first reusable slot.
  task automatic probe_table(input in_item_t op, output out_item_t answer);
    int idx;
    int hit;
    int free_slot;
    int visited;
    logic [STATUS_W-1:0] st;
    idx = int'(op.key % TABLE_SIZE);
    hit = -1;
    free_slot = -1;
    visited = 0;
    st = ST_NOT_FOUND;
    for (int n = 0; n < TABLE_SIZE; n++) begin
      visited++;
      if (shadow_mark[idx] == MARK_EMPTY) begin
        if (free_slot < 0) free_slot = idx;
        break;
      end
      if (shadow_mark[idx] == MARK_USED && shadow_key[idx] == op.key) begin
        hit = idx;
        break;
      end
      if (shadow_mark[idx] != MARK_USED && free_slot < 0) free_slot = idx;
      idx = (idx + 1) % TABLE_SIZE;
    end
    if (visited > longest_probe) longest_probe = visited;

    answer.slot = '0;
    case (op.mode)
      MODE_INSERT: begin
        if (hit >= 0) begin
          st = ST_DUPLICATE;
          answer.slot = OUT_SLOT_W'(hit);
        end else if (free_slot < 0) begin
          st = ST_FULL;
        end else begin
          shadow_key[free_slot] = op.key;
          shadow_mark[free_slot] = MARK_USED;
          st = ST_INSERTED;
          answer.slot = OUT_SLOT_W'(free_slot);
        end
      end
      MODE_SEARCH: begin
        if (hit >= 0) begin
          st = ST_FOUND;
          answer.slot = OUT_SLOT_W'(hit);
        end
      end
      MODE_DELETE: begin
        if (hit >= 0) begin
          shadow_mark[hit] = MARK_GONE;
          st = ST_DELETED;
          answer.slot = OUT_SLOT_W'(hit);
        end
      end
      default: st = ST_NOT_FOUND;
    endcase
    answer.status = st;
  endtask

  always @(posedge clk) begin
    out_item_t predicted;
    out_item_t oldest;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_SIZE; i++) shadow_mark[i] = MARK_EMPTY;
      pending_answers.delete();
      fail_count = 0;
      beats_checked = 0;
      full_seen = 0;
      dup_seen = 0;
      deleted_seen = 0;
      longest_probe = 0;
      outstanding <= 0;
    end else begin
      // The result side is handled first, so a stray result beat can never
      // consume an answer predicted at the same edge.
      if (pop && !empty) begin
        if (pending_answers.size() == 0) begin
          $error("result beat with no answer waiting: status %0d slot %0d",
                 out_item.status, out_item.slot);
          fail_count++;
        end else begin
          oldest = pending_answers.pop_front();
          beats_checked++;
          if (oldest.status == ST_FULL) full_seen++;
          if (oldest.status == ST_DUPLICATE) dup_seen++;
          if (oldest.status == ST_DELETED) deleted_seen++;
          if (out_item.status !== oldest.status) begin
            $error("status mismatch: expected %0d, actual %0d", oldest.status,
                   out_item.status);
            fail_count++;
          end
          if (out_item.slot !== oldest.slot) begin
            $error("slot mismatch: expected %0d, actual %0d", oldest.slot,
                   out_item.slot);
            fail_count++;
          end
        end
      end
      if (push && !full) begin
        probe_table(in_item, predicted);
        pending_answers.push_back(predicted);
      end
      outstanding <= pending_answers.size();
    end
  end

endmodule

// ----- tb/linear_probe_hash_table_tb.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for the linear probing hash table. The checker beside
// the block predicts and compares every beat; this module only decides what
// operations to offer, how the two sides stall, and when the run is over.
module linear_probe_hash_table_tb;

  import lpht_pkg::*;

  localparam int TABLE_SIZE = TABLE_SIZE_DEF;

  // Mode value with no operation behind it; the block must answer not found.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 1100;
  localparam int HOLD_CYCLES  = 400;

  // After the last answer the block may still be probing nothing; the tail
  // leaves room for a full sweep of the table plus the front end.
  localparam int TAIL_CYCLES = 150;

  // The slowest correct run: every beat probing all 32 slots, the longest
  // sender gap, the receiver popping one beat in four, and one receiver hold.
  // Even that stays far below CYCLE_LIMIT for all the beats of a run, a wide margin.
  localparam int CYCLE_LIMIT = 1_000_000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      push = 1'b0;
  logic      pop = 1'b0;
  in_item_t  in_item = '0;
  logic      full;
  logic      empty;
  out_item_t out_item;

  int fail_count;
  int outstanding;
  int beats_checked;
  int full_seen;
  int dup_seen;
  int deleted_seen;
  int longest_probe;

  int items_sent = 0;
  int directed_sent = 0;
  int burst_left = 0;
  int hold_reqs = 0;
  int holds_served = 0;
  int hold_left = 0;
  int pop_style = 0;
  int style_left = 0;
  int cycles = 0;

  linear_probe_hash_table #(
    .TABLE_SIZE(TABLE_SIZE)
  ) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .empty   (empty),
    .pop     (pop),
    .out_item(out_item)
  );

  hash_table_checker #(
    .TABLE_SIZE(TABLE_SIZE)
  ) checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_item      (in_item),
    .empty        (empty),
    .pop          (pop),
    .out_item     (out_item),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .beats_checked(beats_checked),
    .full_seen    (full_seen),
    .dup_seen     (dup_seen),
    .deleted_seen (deleted_seen),
    .longest_probe(longest_probe)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog. A hung handshake ends the run here instead of hanging forever.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("run stopped at the cycle limit with %0d answers outstanding", outstanding);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver. When a style runs out it picks a new stall style at random:
  // always ready, coin flip, one pop in four, or mostly ready. A hold request
  // from the stimulus side makes it refuse results until its hold counter runs
  // out, which backs the block up until it raises full.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != holds_served) begin
      pop <= 1'b0;
      holds_served <= holds_served + 1;
      hold_left <= HOLD_CYCLES;
    end else begin
      if (style_left == 0) begin
        pop_style = $urandom_range(0, 3);
        style_left = $urandom_range(20, 200);
      end else begin
        style_left = style_left - 1;
      end
      case (pop_style)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom_range(0, 1));
        2: pop <= ($urandom_range(0, 3) == 0);
        default: pop <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // A random key whose home slot is the given one. The high bits are random,
  // so every key bit gets exercised while the probe pattern stays controlled.
  function automatic logic [KEY_W-1:0] key_at_home(input int home);
    logic [KEY_W-1:0] k;
    k = KEY_W'($urandom());
    k = KEY_W'(k - (k % TABLE_SIZE) + home);
    return k;
  endfunction

  // Offers one beat and waits until the block takes it. The sender runs in
  // bursts; between most bursts push drops for a random gap. Push is left high on
  // return, so back-to-back beats never lower and raise it in the same step.
  task automatic offer_beat(input logic [MODE_W-1:0] m, input logic [KEY_W-1:0] k);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    push <= 1'b1;
    in_item <= {m, k};
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
  endtask

  // Stops offering and waits until every predicted answer has been checked.
  // The first edge lets the checker count the beat taken at the last edge.
  task automatic drain_answers();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Operations on a small pool of keys whose home slots sit in a run of four
  // adjacent slots, so probes run through clusters, wrap and meet tombstones.
  task automatic cluster_phase();
    logic [KEY_W-1:0]  pool [$];
    logic [KEY_W-1:0]  k;
    logic [MODE_W-1:0] m;
    int base;
    int pick;
    base = $urandom_range(0, TABLE_SIZE - 1);
    repeat ($urandom_range(3, 12)) begin
      pool.push_back(key_at_home((base + $urandom_range(0, 3)) % TABLE_SIZE));
    end
    repeat ($urandom_range(20, 60)) begin
      pick = $urandom_range(0, 99);
      k = pool[$urandom_range(0, pool.size() - 1)];
      if (pick < 40) begin
        m = MODE_INSERT;
      end else if (pick < 70) begin
        m = MODE_SEARCH;
      end else if (pick < 95) begin
        m = MODE_DELETE;
      end else begin
        // A fresh key into the same cluster: usually a miss after a long probe.
        m = MODE_SEARCH;
        k = key_at_home(base);
      end
      offer_beat(m, k);
    end
    // Most phases clean up after themselves so the table does not silt up.
    if ($urandom_range(0, 9) < 7) begin
      foreach (pool[i]) offer_beat(MODE_DELETE, pool[i]);
    end
  endtask

  // Fills the table past capacity, works on the full table, punches holes and
  // refills them, deletes everything it put in, then runs searches and one insert.
  task automatic fill_phase();
    logic [KEY_W-1:0] pool [$];
    logic [KEY_W-1:0] k;
    int victim;
    repeat (TABLE_SIZE + 4) begin
      k = KEY_W'($urandom());
      pool.push_back(k);
      offer_beat(MODE_INSERT, k);
    end
    // With every slot occupied a miss has to visit the whole table.
    repeat (10) begin
      if ($urandom_range(0, 1) == 0) begin
        offer_beat(MODE_SEARCH, pool[$urandom_range(0, pool.size() - 1)]);
      end else begin
        offer_beat(MODE_SEARCH, KEY_W'($urandom()));
      end
    end
    offer_beat(MODE_INSERT, pool[$urandom_range(0, pool.size() - 1)]);
    repeat (4) begin
      victim = $urandom_range(0, pool.size() - 1);
      offer_beat(MODE_DELETE, pool[victim]);
      k = KEY_W'($urandom());
      pool.push_back(k);
      offer_beat(MODE_INSERT, k);
    end
    foreach (pool[i]) offer_beat(MODE_DELETE, pool[i]);
    // A table made mostly of tombstones: misses again run all the way round.
    repeat (4) offer_beat(MODE_SEARCH, KEY_W'($urandom()));
    offer_beat(MODE_INSERT, KEY_W'($urandom()));
  endtask

  // Unshaped traffic: any mode, including the unused one, and any key.
  task automatic noise_phase();
    repeat ($urandom_range(20, 40)) begin
      offer_beat(MODE_W'($urandom_range(0, 3)), KEY_W'($urandom()));
    end
  endtask

  initial begin
    int phase_no;
    int sel;
    phase_no = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. The table starts empty, so a search or delete stops at
    // the home slot at once.
    offer_beat(MODE_SEARCH, KEY_W'(0));
    offer_beat(MODE_DELETE, KEY_W'(5));
    offer_beat(MODE_INSERT, KEY_W'(0));
    offer_beat(MODE_INSERT, {KEY_W{1'b1}});
    // Home slot 31 is taken and slot 0 too, so this one wraps to slot 1.
    offer_beat(MODE_INSERT, KEY_W'(31));
    offer_beat(MODE_INSERT, {KEY_W{1'b1}});
    offer_beat(MODE_INSERT, KEY_W'(32));
    offer_beat(MODE_SEARCH, KEY_W'(31));
    // Slot 31 becomes a tombstone; the search for 31 has to probe past it.
    offer_beat(MODE_DELETE, {KEY_W{1'b1}});
    offer_beat(MODE_SEARCH, KEY_W'(31));
    offer_beat(MODE_SEARCH, {KEY_W{1'b1}});
    offer_beat(MODE_DELETE, {KEY_W{1'b1}});
    // The insert of 63 reuses the tombstone at 31 after checking the cluster.
    offer_beat(MODE_INSERT, KEY_W'(63));
    offer_beat(MODE_DELETE, KEY_W'(63));
    // A duplicate that sits behind a tombstone must still be reported.
    offer_beat(MODE_INSERT, KEY_W'(31));
    offer_beat(MODE_UNUSED, KEY_W'(0));
    offer_beat(MODE_UNUSED, {KEY_W{1'b1}});
    offer_beat(MODE_SEARCH, KEY_W'(32));
    offer_beat(MODE_DELETE, KEY_W'(0));
    offer_beat(MODE_DELETE, KEY_W'(31));
    offer_beat(MODE_DELETE, KEY_W'(32));
    offer_beat(MODE_SEARCH, KEY_W'(32));
    directed_sent = items_sent;
    drain_answers();

    // Random part. The second phase is always a fill, run under a long
    // receiver hold so the block backs up and stalls the sender.
    while (items_sent < directed_sent + RANDOM_ITEMS) begin
      if (phase_no == 1) begin
        hold_reqs <= hold_reqs + 1;
        fill_phase();
      end else begin
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
          cluster_phase();
        end else if (sel < 8) begin
          fill_phase();
        end else begin
          noise_phase();
        end
      end
      if (phase_no == 0 || $urandom_range(0, 3) == 0) drain_answers();
      phase_no++;
    end

    drain_answers();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Offered %0d operation beats (%0d directed) in %0d random phases;",
             items_sent, directed_sent, phase_no);
    $display("%0d results checked, covering %0d table-full, %0d duplicate, %0d deleted;",
             beats_checked, full_seen, dup_seen, deleted_seen);
    $display("longest probe %0d slots.", longest_probe);
    if (fail_count == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/lpht_pkg.sv
rtl/lpht_front.sv
rtl/lpht_queue.sv
rtl/lpht_back.sv
rtl/linear_probe_hash_table.sv
tb/hash_table_checker.sv
tb/linear_probe_hash_table_tb.sv
